>>> src/btpl_pkg.sv
// Shared command codes, status codes and value width of the trie prefix lookup block.
package btpl_pkg;

  localparam int VAL_W = 31;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EXISTS = 2'd1,
    ST_MISS   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage

>>> src/btpl_if.sv
// Valid/ready channel interfaces for command items and result items.
interface btpl_in_if import btpl_pkg::*; #(parameter int ADDR_BITS = 32);
  logic                             valid;
  logic                             ready;
  logic [1:0]                       cmd;
  logic [ADDR_BITS-1:0]             address;
  logic [$clog2(ADDR_BITS+1)-1:0]   prefix_len;
  logic [VAL_W-1:0]                 route_value;

  modport source (output valid, cmd, address, prefix_len, route_value, input ready);
  modport sink   (input valid, cmd, address, prefix_len, route_value, output ready);
endinterface

interface btpl_out_if import btpl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             match_found;
  logic [VAL_W-1:0] match_value;

  modport source (output valid, status, match_found, match_value, input ready);
  modport sink   (input valid, status, match_found, match_value, output ready);
endinterface

>>> src/binary_trie_prefix_lookup.sv
// Each level is walked in S_STEP: an existing node is read through S_LOAD, a node made from
// the fresh counter needs no read, and one popped from the free stack goes through S_POP.
// Delete then climbs back up level by level (path memory read, then node memory read).
// One command is in work at a time; the next is accepted the cycle after the result loads,
// later while an earlier result waits for out_ch.ready. Reset (synchronous, active low)
// empties the root and the allocators; node, free-stack and path memories are not cleared.
module binary_trie_prefix_lookup import btpl_pkg::*; #(
  parameter int NODE_COUNT = 4096,
  parameter int ADDR_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  btpl_in_if.sink    in_ch,
  btpl_out_if.source out_ch
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int LW = $clog2(ADDR_BITS + 1);

  typedef struct packed {
    logic             has_val;
    logic [VAL_W-1:0] val;
    logic [1:0]       has_kid;
    logic [IW-1:0]    kid1;
    logic [IW-1:0]    kid0;
  } node_t;

  typedef struct packed {
    logic          is_root;
    logic [IW-1:0] idx;
  } ref_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_STEP  = 8'b0000_0010,
    S_LOAD  = 8'b0000_0100,
    S_POP   = 8'b0000_1000,
    S_PPATH = 8'b0001_0000,
    S_PNODE = 8'b0010_0000,
    S_PLOAD = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Memories.
  node_t nm [NODE_COUNT];
  logic [IW-1:0] fs [NODE_COUNT];
  ref_t pm [ADDR_BITS+1];

  node_t nm_rdata_r;
  logic [IW-1:0] fs_rdata_r;
  ref_t pm_rdata_r;

  logic nm_we, fs_we, pm_we;
  logic [IW-1:0] nm_waddr, nm_raddr, fs_waddr, fs_raddr;
  node_t nm_wdata;
  logic [IW-1:0] fs_wdata;
  logic [LW-1:0] pm_waddr, pm_raddr;
  ref_t pm_wdata;

  // Registers.
  state_t state_r, state_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [LW-1:0] len_r, len_nxt, lvl_r, lvl_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [ADDR_BITS-1:0] sh_r, sh_nxt;
  logic cur_root_r, cur_root_nxt;
  logic [IW-1:0] cur_idx_r, cur_idx_nxt;
  node_t cur_node_r, cur_node_nxt;
  logic dirty_r, dirty_nxt;
  node_t root_r, root_nxt;
  logic [IW:0] fcnt_r, fcnt_nxt, fresh_r, fresh_nxt;
  status_t status_r, status_nxt;
  logic found_r, found_nxt;
  logic [VAL_W-1:0] mval_r, mval_nxt;
  logic prune_r, prune_nxt;
  ref_t pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  logic out_found_r, out_found_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;

  logic b_dn, b_up, kid_has, node_empty, wb_en;
  logic [IW-1:0] kid_idx;
  logic [LW-1:0] in_len;
  node_t wb_node, up_node;

  function automatic node_t set_kid(node_t n, logic b, logic h, logic [IW-1:0] k);
    node_t r;
    r = n;
    r.has_kid[b] = h;
    if (b) r.kid1 = k;
    else   r.kid0 = k;
    return r;
  endfunction

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.match_found = out_found_r;
  assign out_ch.match_value = out_value_r;

  assign in_len = (in_ch.prefix_len > LW'(ADDR_BITS)) ? LW'(ADDR_BITS) : in_ch.prefix_len;
  assign b_dn = sh_r[ADDR_BITS-1];
  assign b_up = sh_r[0];
  assign kid_has = cur_node_r.has_kid[b_dn];
  assign kid_idx = b_dn ? cur_node_r.kid1 : cur_node_r.kid0;
  assign node_empty = !cur_node_r.has_val && (cur_node_r.has_kid == 2'b00);
  assign up_node = pend_r.is_root ? root_r : nm_rdata_r;

  always_comb begin
    state_nxt = state_r;  cmd_nxt = cmd_r;  len_nxt = len_r;  lvl_nxt = lvl_r;
    val_nxt = val_r;  sh_nxt = sh_r;  cur_root_nxt = cur_root_r;  cur_idx_nxt = cur_idx_r;
    cur_node_nxt = cur_node_r;  dirty_nxt = dirty_r;  root_nxt = root_r;
    fcnt_nxt = fcnt_r;  fresh_nxt = fresh_r;  status_nxt = status_r;
    found_nxt = found_r;  mval_nxt = mval_r;  prune_nxt = prune_r;  pend_nxt = pend_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;  out_found_nxt = out_found_r;  out_value_nxt = out_value_r;
    nm_we = 1'b0;  nm_waddr = cur_idx_r;  nm_wdata = cur_node_r;  nm_raddr = kid_idx;
    fs_we = 1'b0;  fs_waddr = fcnt_r[IW-1:0];  fs_wdata = cur_idx_r;
    fs_raddr = fcnt_r[IW-1:0] - IW'(1);
    pm_we = 1'b0;  pm_waddr = lvl_r;  pm_wdata = '{is_root: cur_root_r, idx: cur_idx_r};
    pm_raddr = lvl_r - LW'(1);
    wb_en = 1'b0;  wb_node = cur_node_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = cmd_t'(in_ch.cmd);
          len_nxt = (cmd_t'(in_ch.cmd) == CMD_LOOKUP) ? LW'(ADDR_BITS) : in_len;
          val_nxt = in_ch.route_value;
          sh_nxt = in_ch.address;
          lvl_nxt = '0;
          cur_root_nxt = 1'b1;
          cur_node_nxt = root_r;
          dirty_nxt = 1'b0;
          found_nxt = 1'b0;
          mval_nxt = '0;
          status_nxt = (cmd_t'(in_ch.cmd) == CMD_INSERT) ? ST_OK : ST_MISS;
          state_nxt = (cmd_t'(in_ch.cmd) == CMD_RSVD) ? S_DONE : S_STEP;
        end
      end
      S_STEP: begin
        if (cmd_r == CMD_LOOKUP && cur_node_r.has_val) begin
          found_nxt = 1'b1;
          mval_nxt = cur_node_r.val;
        end
        if (cmd_r == CMD_DELETE) pm_we = 1'b1;
        if (lvl_r == len_r) begin
          state_nxt = S_DONE;
          unique case (cmd_r)
            CMD_INSERT: begin
              wb_en = 1'b1;
              if (cur_node_r.has_val) begin
                status_nxt = ST_EXISTS;
                wb_en = dirty_r;
              end else begin
                wb_node.has_val = 1'b1;
                wb_node.val = val_r;
              end
            end
            CMD_DELETE: begin
              if (cur_node_r.has_val) begin
                cur_node_nxt.has_val = 1'b0;
                cur_node_nxt.val = '0;
                dirty_nxt = 1'b1;
                status_nxt = ST_OK;
                if (lvl_r == '0) begin
                  wb_en = 1'b1;
                  wb_node.has_val = 1'b0;
                  wb_node.val = '0;
                end
              end
              if (lvl_r != '0) state_nxt = S_PPATH;
            end
            CMD_LOOKUP: status_nxt = (found_r || cur_node_r.has_val) ? ST_OK : ST_MISS;
            default: ;
          endcase
        end else if (kid_has) begin
          pend_nxt = '{is_root: 1'b0, idx: kid_idx};
          wb_en = dirty_r;
          state_nxt = S_LOAD;
        end else begin
          unique case (cmd_r)
            CMD_INSERT: begin
              if (fcnt_r != '0) begin
                fcnt_nxt = fcnt_r - (IW+1)'(1);
                state_nxt = S_POP;
              end else if (fresh_r < (IW+1)'(NODE_COUNT)) begin
                fresh_nxt = fresh_r + (IW+1)'(1);
                wb_en = 1'b1;
                wb_node = set_kid(cur_node_r, b_dn, 1'b1, fresh_r[IW-1:0]);
                cur_root_nxt = 1'b0;
                cur_idx_nxt = fresh_r[IW-1:0];
                cur_node_nxt = '0;
                dirty_nxt = 1'b1;
                lvl_nxt = lvl_r + LW'(1);
                sh_nxt = {sh_r[ADDR_BITS-2:0], sh_r[ADDR_BITS-1]};
              end else begin
                status_nxt = ST_FULL;
                wb_en = dirty_r;
                state_nxt = S_DONE;
              end
            end
            CMD_DELETE: state_nxt = (lvl_r == '0) ? S_DONE : S_PPATH;
            CMD_LOOKUP: begin
              status_nxt = (found_r || cur_node_r.has_val) ? ST_OK : ST_MISS;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        cur_node_nxt = nm_rdata_r;
        cur_root_nxt = 1'b0;
        cur_idx_nxt = pend_r.idx;
        dirty_nxt = 1'b0;
        lvl_nxt = lvl_r + LW'(1);
        sh_nxt = {sh_r[ADDR_BITS-2:0], sh_r[ADDR_BITS-1]};
        state_nxt = S_STEP;
      end
      S_POP: begin
        wb_en = 1'b1;
        wb_node = set_kid(cur_node_r, b_dn, 1'b1, fs_rdata_r);
        cur_root_nxt = 1'b0;
        cur_idx_nxt = fs_rdata_r;
        cur_node_nxt = '0;
        dirty_nxt = 1'b1;
        lvl_nxt = lvl_r + LW'(1);
        sh_nxt = {sh_r[ADDR_BITS-2:0], sh_r[ADDR_BITS-1]};
        state_nxt = S_STEP;
      end
      S_PPATH: begin
        // The current node sits below the root here; an empty one goes back on the free stack.
        prune_nxt = node_empty;
        if (node_empty) begin
          if (fcnt_r < (IW+1)'(NODE_COUNT)) begin
            fs_we = 1'b1;
            fcnt_nxt = fcnt_r + (IW+1)'(1);
          end
        end else begin
          wb_en = dirty_r;
        end
        state_nxt = S_PNODE;
      end
      S_PNODE: begin
        pend_nxt = pm_rdata_r;
        nm_raddr = pm_rdata_r.idx;
        state_nxt = S_PLOAD;
      end
      S_PLOAD: begin
        cur_node_nxt = prune_r ? set_kid(up_node, b_up, 1'b0, '0) : up_node;
        cur_root_nxt = pend_r.is_root;
        cur_idx_nxt = pend_r.idx;
        dirty_nxt = prune_r;
        lvl_nxt = lvl_r - LW'(1);
        sh_nxt = {sh_r[0], sh_r[ADDR_BITS-1:1]};
        if (lvl_r == LW'(1)) begin
          root_nxt = cur_node_nxt;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PPATH;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt = found_r;
          out_value_nxt = mval_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (wb_en) begin
      if (cur_root_r) begin
        root_nxt = wb_node;
      end else begin
        nm_we = 1'b1;
        nm_wdata = wb_node;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nm_we) nm[nm_waddr] <= nm_wdata;
    nm_rdata_r <= nm[nm_raddr];
    if (fs_we) fs[fs_waddr] <= fs_wdata;
    fs_rdata_r <= fs[fs_raddr];
    if (pm_we) pm[pm_waddr] <= pm_wdata;
    pm_rdata_r <= pm[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      root_r <= '0;
      fcnt_r <= '0;
      fresh_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      root_r <= root_nxt;
      fcnt_r <= fcnt_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;  len_r <= len_nxt;  lvl_r <= lvl_nxt;  val_r <= val_nxt;
    sh_r <= sh_nxt;  cur_root_r <= cur_root_nxt;  cur_idx_r <= cur_idx_nxt;
    cur_node_r <= cur_node_nxt;  dirty_r <= dirty_nxt;  status_r <= status_nxt;
    found_r <= found_nxt;  mval_r <= mval_nxt;  prune_r <= prune_nxt;  pend_r <= pend_nxt;
    out_status_r <= out_status_nxt;  out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
  end

  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= (IW+1)'(NODE_COUNT))
    else $error("free stack count beyond node count");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= (IW+1)'(NODE_COUNT))
    else $error("fresh node counter beyond node count");

  a_walk_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (lvl_r <= len_r))
    else $error("trie walk deeper than prefix length");

  a_prune_nonroot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PPATH) |-> (!cur_root_r && lvl_r != '0))
    else $error("pruning reached the root node");

endmodule
